### rtl/gdc_pkg.sv
package gdc_pkg;

	localparam logic [1:0] CMD_FWD  = 2'd0;
	localparam logic [1:0] CMD_BACK = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	localparam logic [26:0] PACK_LIMIT = 27'd100000000;
	// floor(v / 10000) = (v * RECIP_1E4) >> 41, exact for any 27-bit v
	localparam logic [27:0] RECIP_1E4  = 28'd219902326;
	localparam int          SHIFT_1E4  = 41;
	// floor(v / 100) = (v * RECIP_100) >> 21, exact for any 14-bit v
	localparam logic [14:0] RECIP_100  = 15'd20972;
	localparam int          SHIFT_100  = 21;

	localparam logic [6:0] RST_CENT = 7'd19;
	localparam logic [6:0] RST_YOC  = 7'd70;
	localparam logic [3:0] RST_MON  = 4'd1;
	localparam logic [4:0] RST_DAY  = 5'd1;
	localparam logic [26:0] RST_PACK = 27'd19700101;

	// load operands after decode, year split into century and year of century
	typedef struct packed {
		logic [1:0] cmd;
		logic       load_ok;
		logic [6:0] cent;
		logic [6:0] yoc;
		logic [3:0] month;
		logic [4:0] day;
	} dec_t;

	typedef struct packed {
		logic [6:0] cent;
		logic [6:0] yoc;
		logic [3:0] month;
		logic [4:0] day;
		logic       leap;
		logic       load_ok;
	} date_t;

	function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yoc);
		logic lp;
		if (yoc == 7'd0) begin
			lp = (cent[1:0] == 2'd0);
		end else begin
			lp = (yoc[1:0] == 2'd0);
		end
		return lp;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### rtl/gdc_req_if.sv
interface gdc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [26:0] load_value;

	modport source (output valid, output cmd, output load_value, input ready);
	modport sink (input valid, input cmd, input load_value, output ready);
endinterface

### rtl/gdc_rsp_if.sv
interface gdc_rsp_if;
	logic        valid;
	logic        ready;
	logic [13:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [26:0] packed_now;
	logic [26:0] packed_before;
	logic        leap_flag;
	logic        load_ok;

	modport source (output valid, output year_out, output month_out, output day_out,
		output packed_now, output packed_before, output leap_flag, output load_ok,
		input ready);
	modport sink (input valid, input year_out, input month_out, input day_out,
		input packed_now, input packed_before, input leap_flag, input load_ok,
		output ready);
endinterface

### rtl/gdc_load_dec.sv
module gdc_load_dec (
	input  logic          clk,
	input  logic          arst_n,
	gdc_req_if.sink       req,
	output logic          dec_valid,
	input  logic          dec_ready,
	output gdc_pkg::dec_t dec
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [1:0]  cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [26:0] val_s1, val_s2;
	logic        big_ok_s2, big_ok_s3, big_ok_s4;
	logic [13:0] q_s2, q_s3;
	logic [13:0] r_s3, r_s4;
	logic [7:0]  yc_s3, yc_s4;
	logic [6:0]  m_s4, yl_s4;
	gdc_pkg::dec_t dec_s5;

	logic [54:0] prod_q;
	logic [26:0] rem_full;
	logic [28:0] prod_yc;
	logic [27:0] prod_m;
	logic [13:0] yl_full;
	logic [13:0] d_full;
	logic [6:0]  d7;
	logic        leap_ld;
	logic [4:0]  mlen_ld;
	logic        mon_ok, day_ok;

	assign rdy5 = !v_s5 || dec_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req.ready = rdy1;
	assign dec_valid = v_s5;
	assign dec = dec_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// quotient by 10000 gives the year
	assign prod_q = 55'(val_s1) * 55'(gdc_pkg::RECIP_1E4);

	// remainder gives mmdd, year split into century and year of century
	assign rem_full = val_s2 - 27'(q_s2) * 27'd10000;
	assign prod_yc  = 29'(q_s2) * 29'(gdc_pkg::RECIP_100);

	assign prod_m  = 28'(r_s3) * 28'(gdc_pkg::RECIP_100);
	assign yl_full = q_s3 - 14'(yc_s3) * 14'd100;

	assign d_full  = r_s4 - 14'(m_s4) * 14'd100;
	assign d7      = d_full[6:0];
	assign leap_ld = gdc_pkg::is_leap(yc_s4[6:0], yl_s4);
	assign mlen_ld = gdc_pkg::month_len(m_s4[3:0], leap_ld);
	assign mon_ok  = (m_s4 >= 7'd1) && (m_s4 <= 7'd12);
	assign day_ok  = (d7 != 7'd0) && (d7 <= 7'(mlen_ld));

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			cmd_s1 <= req.cmd;
			val_s1 <= req.load_value;
		end
		if (rdy2 && v_s1) begin
			cmd_s2    <= cmd_s1;
			val_s2    <= val_s1;
			big_ok_s2 <= (val_s1 < gdc_pkg::PACK_LIMIT);
			q_s2      <= prod_q[gdc_pkg::SHIFT_1E4 +: 14];
		end
		if (rdy3 && v_s2) begin
			cmd_s3    <= cmd_s2;
			big_ok_s3 <= big_ok_s2;
			q_s3      <= q_s2;
			r_s3      <= rem_full[13:0];
			yc_s3     <= prod_yc[gdc_pkg::SHIFT_100 +: 8];
		end
		if (rdy4 && v_s3) begin
			cmd_s4    <= cmd_s3;
			big_ok_s4 <= big_ok_s3;
			r_s4      <= r_s3;
			yc_s4     <= yc_s3;
			m_s4      <= prod_m[gdc_pkg::SHIFT_100 +: 7];
			yl_s4     <= yl_full[6:0];
		end
		if (rdy5 && v_s4) begin
			dec_s5.cmd     <= cmd_s4;
			dec_s5.load_ok <= (cmd_s4 == gdc_pkg::CMD_LOAD) && big_ok_s4 && mon_ok && day_ok;
			dec_s5.cent    <= yc_s4[6:0];
			dec_s5.yoc     <= yl_s4;
			dec_s5.month   <= m_s4[3:0];
			dec_s5.day     <= d7[4:0];
		end
	end

endmodule

### rtl/gdc_step.sv
module gdc_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           dec_valid,
	output logic           dec_ready,
	input  gdc_pkg::dec_t  dec,
	output logic           date_valid,
	input  logic           date_ready,
	output gdc_pkg::date_t date
);

	logic [6:0] cent_q, yoc_q;
	logic [3:0] mon_q;
	logic [4:0] day_q;
	logic       v_s6;
	gdc_pkg::date_t date_s6;

	logic       fire;
	logic       leap_cur;
	logic [4:0] mlen_cur;
	logic [4:0] mlen_prev;
	logic [3:0] mon_prev;
	logic [6:0] cent_inc, yoc_inc, cent_dec, yoc_dec;
	logic [6:0] cent_d, yoc_d;
	logic [3:0] mon_d;
	logic [4:0] day_d;

	assign dec_ready  = !v_s6 || date_ready;
	assign fire       = dec_valid && dec_ready;
	assign date_valid = v_s6;
	assign date       = date_s6;

	assign leap_cur  = gdc_pkg::is_leap(cent_q, yoc_q);
	assign mlen_cur  = gdc_pkg::month_len(mon_q, leap_cur);
	assign mon_prev  = mon_q - 4'd1;
	assign mlen_prev = gdc_pkg::month_len(mon_prev, leap_cur);

	always_comb begin
		if (yoc_q == 7'd99) begin
			yoc_inc  = 7'd0;
			cent_inc = (cent_q == 7'd99) ? 7'd0 : cent_q + 7'd1;
		end else begin
			yoc_inc  = yoc_q + 7'd1;
			cent_inc = cent_q;
		end
		if (yoc_q == 7'd0) begin
			yoc_dec  = 7'd99;
			cent_dec = (cent_q == 7'd0) ? 7'd99 : cent_q - 7'd1;
		end else begin
			yoc_dec  = yoc_q - 7'd1;
			cent_dec = cent_q;
		end
	end

	always_comb begin
		cent_d = cent_q;
		yoc_d  = yoc_q;
		mon_d  = mon_q;
		day_d  = day_q;
		case (dec.cmd)
			gdc_pkg::CMD_FWD: begin
				if (day_q < mlen_cur) begin
					day_d = day_q + 5'd1;
				end else begin
					day_d = 5'd1;
					if (mon_q < 4'd12) begin
						mon_d = mon_q + 4'd1;
					end else begin
						mon_d  = 4'd1;
						cent_d = cent_inc;
						yoc_d  = yoc_inc;
					end
				end
			end
			gdc_pkg::CMD_BACK: begin
				if (day_q > 5'd1) begin
					day_d = day_q - 5'd1;
				end else if (mon_q > 4'd1) begin
					mon_d = mon_prev;
					day_d = mlen_prev;
				end else begin
					mon_d  = 4'd12;
					day_d  = 5'd31;
					cent_d = cent_dec;
					yoc_d  = yoc_dec;
				end
			end
			gdc_pkg::CMD_LOAD: begin
				if (dec.load_ok) begin
					cent_d = dec.cent;
					yoc_d  = dec.yoc;
					mon_d  = dec.month;
					day_d  = dec.day;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cent_q <= gdc_pkg::RST_CENT;
			yoc_q  <= gdc_pkg::RST_YOC;
			mon_q  <= gdc_pkg::RST_MON;
			day_q  <= gdc_pkg::RST_DAY;
			v_s6   <= 1'b0;
		end else begin
			if (dec_ready) v_s6 <= dec_valid;
			if (fire) begin
				cent_q <= cent_d;
				yoc_q  <= yoc_d;
				mon_q  <= mon_d;
				day_q  <= day_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			date_s6.cent    <= cent_d;
			date_s6.yoc     <= yoc_d;
			date_s6.month   <= mon_d;
			date_s6.day     <= day_d;
			date_s6.leap    <= gdc_pkg::is_leap(cent_d, yoc_d);
			date_s6.load_ok <= dec.load_ok;
		end
	end

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mon_q >= 4'd1) && (mon_q <= 4'd12) && (day_q >= 5'd1) && (day_q <= mlen_cur))
		else $error("date register out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cent_q <= 7'd99) && (yoc_q <= 7'd99))
		else $error("year register out of range");

	a_fwd_inc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (dec.cmd == gdc_pkg::CMD_FWD) && (day_q < mlen_cur)
		|=> (day_q == $past(day_q) + 5'd1) && $stable(mon_q) && $stable(yoc_q))
		else $error("forward step within month broken");

	a_bad_load: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (dec.cmd == gdc_pkg::CMD_LOAD) && !dec.load_ok
		|=> $stable(cent_q) && $stable(yoc_q) && $stable(mon_q) && $stable(day_q))
		else $error("rejected load changed the date");

endmodule

### rtl/gdc_pack.sv
module gdc_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           date_valid,
	output logic           date_ready,
	input  gdc_pkg::date_t date,
	gdc_rsp_if.source      rsp
);

	logic        v_s7;
	logic [26:0] last_pack_q;
	logic [13:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  day_s7;
	logic [26:0] now_s7, before_s7;
	logic        leap_s7, ok_s7;

	logic        fire;
	logic [13:0] year_c;
	logic [26:0] pack_c;

	assign date_ready = !v_s7 || rsp.ready;
	assign fire       = date_valid && date_ready;

	assign year_c = 14'(date.cent) * 14'd100 + 14'(date.yoc);
	assign pack_c = 27'(date.cent) * 27'd1000000 + 27'(date.yoc) * 27'd10000
		+ 27'(date.month) * 27'd100 + 27'(date.day);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7        <= 1'b0;
			last_pack_q <= gdc_pkg::RST_PACK;
		end else begin
			if (date_ready) v_s7 <= date_valid;
			if (fire) last_pack_q <= pack_c;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			year_s7   <= year_c;
			month_s7  <= date.month;
			day_s7    <= date.day;
			now_s7    <= pack_c;
			before_s7 <= last_pack_q;
			leap_s7   <= date.leap;
			ok_s7     <= date.load_ok;
		end
	end

	assign rsp.valid         = v_s7;
	assign rsp.year_out      = year_s7;
	assign rsp.month_out     = month_s7;
	assign rsp.day_out       = day_s7;
	assign rsp.packed_now    = now_s7;
	assign rsp.packed_before = before_s7;
	assign rsp.leap_flag     = leap_s7;
	assign rsp.load_ok       = ok_s7;

	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (before_s7 == $past(last_pack_q)) && (last_pack_q == now_s7))
		else $error("packed_before does not follow the previous date");

	a_pack_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (now_s7 <= 27'd99991231) && (year_s7 <= 14'd9999))
		else $error("packed date out of range");

endmodule

### rtl/gregorian_date_up_down_counter_core.sv
// channel  dir  fields                                             transaction
// req      in   cmd, load_value                                    valid && ready
// rsp      out  year_out, month_out, day_out, packed_now,          valid && ready
//               packed_before, leap_flag, load_ok
//
// one transaction per cycle sustained while rsp is ready
// load decode runs in five pipeline stages ahead of the date registers,
// one stage updates the date, one packs the result into the output register
// reset sets the date to 1970-01-01, no clearing pass
// a stalled rsp back-pressures stage by stage, empty stages keep accepting
module gregorian_date_up_down_counter_core (
	input logic       clk,
	input logic       arst_n,
	gdc_req_if.sink   req,
	gdc_rsp_if.source rsp
);

	logic           dec_valid, dec_ready;
	gdc_pkg::dec_t  dec;
	logic           date_valid, date_ready;
	gdc_pkg::date_t date;

	gdc_load_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec)
	);

	gdc_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec        (dec),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date       (date)
	);

	gdc_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date       (date),
		.rsp        (rsp)
	);

endmodule

### test/gregorian_date_up_down_counter_core_tb.sv
`timescale 1ns / 100ps

module gregorian_date_up_down_counter_core_tb;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 1630;
	localparam int PHASES = 8;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [26:0] date_now;
		logic [26:0] date_prev;
		logic        leap;
		logic        load_ok;
	} date_result_t;

	class date_scoreboard;
		int year_q;
		int month_q;
		int day_q;
		date_result_t expected_q[$];
		int mismatches;
		int checked;
		int n_fwd;
		int n_back;
		int n_load_ok;
		int n_load_bad;
		int n_nop;
		int n_wraps;

		function new();
			year_q  = 1970;
			month_q = 1;
			day_q   = 1;
		endfunction

		static function bit leap_year(int y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		static function int month_days(int y, int m);
			case (m)
				4, 6, 9, 11: return 30;
				2:           return leap_year(y) ? 29 : 28;
				default:     return 31;
			endcase
		endfunction

		function int packed_date();
			return year_q * 10000 + month_q * 100 + day_q;
		endfunction

		function void note_command(logic [1:0] c, logic [26:0] v);
			date_result_t r;
			int prev;
			int y;
			int m;
			int d;
			bit ok;
			prev = packed_date();
			ok = 1'b0;
			case (c)
				gdc_pkg::CMD_FWD: begin
					n_fwd++;
					if (day_q < month_days(year_q, month_q)) begin
						day_q++;
					end else begin
						day_q = 1;
						if (month_q < 12) begin
							month_q++;
						end else begin
							month_q = 1;
							year_q = (year_q + 1) % 10000;
							if (year_q == 0)
								n_wraps++;
						end
					end
				end
				gdc_pkg::CMD_BACK: begin
					n_back++;
					if (day_q > 1) begin
						day_q--;
					end else begin
						if (month_q > 1) begin
							month_q--;
						end else begin
							month_q = 12;
							year_q = (year_q + 9999) % 10000;
							if (year_q == 9999)
								n_wraps++;
						end
						day_q = month_days(year_q, month_q);
					end
				end
				gdc_pkg::CMD_LOAD: begin
					if (int'(v) < int'(gdc_pkg::PACK_LIMIT)) begin
						y = int'(v) / 10000;
						m = (int'(v) / 100) % 100;
						d = int'(v) % 100;
						ok = (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_days(y, m));
					end
					if (ok) begin
						year_q  = y;
						month_q = m;
						day_q   = d;
						n_load_ok++;
					end else begin
						n_load_bad++;
					end
				end
				default: n_nop++;
			endcase
			r.year      = year_q[13:0];
			r.month     = month_q[3:0];
			r.day       = day_q[4:0];
			r.date_now  = 27'(packed_date());
			r.date_prev = 27'(prev);
			r.leap      = leap_year(year_q);
			r.load_ok   = ok;
			expected_q = {expected_q, r};
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [26:0] got, logic [26:0] want);
			if (got !== want)
				report_mismatch($sformatf("transaction %0d %s got %0d want %0d",
					checked, name, got, want));
		endtask

		task check_result(date_result_t got);
			date_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("response with no transaction outstanding");
				return;
			end
			want = expected_q.pop_front();
			compare_field("year_out", 27'(got.year), 27'(want.year));
			compare_field("month_out", 27'(got.month), 27'(want.month));
			compare_field("day_out", 27'(got.day), 27'(want.day));
			compare_field("packed_now", got.date_now, want.date_now);
			compare_field("packed_before", got.date_prev, want.date_prev);
			compare_field("leap_flag", 27'(got.leap), 27'(want.leap));
			compare_field("load_ok", 27'(got.load_ok), 27'(want.load_ok));
			checked++;
		endtask

		task check_leftovers();
			while (expected_q.size() != 0) begin
				report_mismatch($sformatf("response never came for date %0d",
					expected_q[0].date_now));
				void'(expected_q.pop_front());
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	date_scoreboard sb = new();

	gdc_req_if req_ch ();
	gdc_rsp_if rsp_ch ();

	gregorian_date_up_down_counter_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always #5ns clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		date_result_t r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			r.year      = rsp_ch.year_out;
			r.month     = rsp_ch.month_out;
			r.day       = rsp_ch.day_out;
			r.date_now  = rsp_ch.packed_now;
			r.date_prev = rsp_ch.packed_before;
			r.leap      = rsp_ch.leap_flag;
			r.load_ok   = rsp_ch.load_ok;
			sb.check_result(r);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	task automatic send_command(input logic [1:0] c, input logic [26:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.load_value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_command(c, v);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic logic [26:0] random_good_date();
		int y;
		int m;
		int d;
		int len;
		case ($urandom_range(9))
			0:       y = 0;
			1:       y = 9999;
			2:       y = $urandom_range(99) * 100;
			3:       y = $urandom_range(24) * 400;
			default: y = $urandom_range(9999);
		endcase
		case ($urandom_range(7))
			0:       m = 2;
			1:       m = 12;
			2:       m = 1;
			default: m = $urandom_range(12, 1);
		endcase
		len = date_scoreboard::month_days(y, m);
		case ($urandom_range(9))
			0, 1, 2, 3: d = len;
			4, 5:       d = 1;
			default:    d = $urandom_range(len, 1);
		endcase
		return 27'(y * 10000 + m * 100 + d);
	endfunction

	function automatic logic [26:0] random_bad_date();
		int y;
		int m;
		int d;
		y = $urandom_range(9999);
		m = $urandom_range(12, 1);
		d = $urandom_range(28, 1);
		case ($urandom_range(3))
			0: return 27'($urandom);
			1: return 27'($urandom_range(134217727, 100000000));
			2: m = ($urandom_range(1) == 0) ? 0 : $urandom_range(99, 13);
			default: d = ($urandom_range(2) == 0) ? 0 :
				$urandom_range(99, date_scoreboard::month_days(y, m) + 1);
		endcase
		return 27'(y * 10000 + m * 100 + d);
	endfunction

	task automatic run_random_phase(input int n);
		int done;
		int len;
		int pick;
		logic [1:0] dir;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				dir = (pick < 35) ? gdc_pkg::CMD_FWD : gdc_pkg::CMD_BACK;
				len = $urandom_range(40, 1);
				repeat (len)
					send_command(dir, 27'($urandom));
				done += len;
			end else if (pick < 82) begin
				send_command(gdc_pkg::CMD_LOAD, random_good_date());
				done++;
			end else if (pick < 95) begin
				send_command(gdc_pkg::CMD_LOAD, random_bad_date());
				done++;
			end else begin
				send_command(CMD_NOP, 27'($urandom));
				done++;
			end
		end
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.cmd        = gdc_pkg::CMD_FWD;
		req_ch.load_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset date, day steps in both directions and a year step back
		send_command(gdc_pkg::CMD_FWD, '0);
		send_command(gdc_pkg::CMD_BACK, '0);
		send_command(gdc_pkg::CMD_BACK, '0);
		// year wrap both ways
		send_command(gdc_pkg::CMD_LOAD, 27'd99991231);
		send_command(gdc_pkg::CMD_FWD, '0);
		send_command(gdc_pkg::CMD_BACK, '0);
		// year zero is a leap year
		send_command(gdc_pkg::CMD_LOAD, 27'd00000228);
		send_command(gdc_pkg::CMD_FWD, '0);
		send_command(gdc_pkg::CMD_FWD, '0);
		// century rule
		send_command(gdc_pkg::CMD_LOAD, 27'd19000228);
		send_command(gdc_pkg::CMD_FWD, '0);
		send_command(gdc_pkg::CMD_LOAD, 27'd20000229);
		send_command(gdc_pkg::CMD_LOAD, 27'd20010229);
		// rejected loads
		send_command(gdc_pkg::CMD_LOAD, 27'd100000000);
		send_command(gdc_pkg::CMD_LOAD, 27'h7FFFFFF);
		send_command(gdc_pkg::CMD_LOAD, 27'd20241301);
		send_command(gdc_pkg::CMD_LOAD, 27'd20240001);
		send_command(gdc_pkg::CMD_LOAD, 27'd20240431);
		send_command(gdc_pkg::CMD_LOAD, 27'd20240100);
		send_command(gdc_pkg::CMD_LOAD, 27'd0);
		// unused command
		send_command(CMD_NOP, 27'd20240101);
		send_command(gdc_pkg::CMD_LOAD, 27'd00000101);
		send_command(gdc_pkg::CMD_BACK, '0);
		send_command(gdc_pkg::CMD_LOAD, 27'd20240301);
		send_command(gdc_pkg::CMD_BACK, '0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			run_random_phase(RANDOM_ITEMS / PHASES);
			wait_drained();
		end

		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		sb.check_leftovers();

		$display("checked %0d responses: %0d forward, %0d back, %0d unused commands",
			sb.checked, sb.n_fwd, sb.n_back, sb.n_nop);
		$display("loads accepted %0d, loads rejected %0d, year wraps %0d, mismatches %0d",
			sb.n_load_ok, sb.n_load_bad, sb.n_wraps, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
